// ===== sv/substring_double_hash_defines.svh =====
// Assertion macros used by the checker of the substring hash block.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef SUBSTRING_DOUBLE_HASH_DEFINES_SVH
`define SUBSTRING_DOUBLE_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define SDH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define SDH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/sdh_pkg.sv =====
// Package of the substring double hash block: sizes, primes, codes, types.
// No dependencies.
`default_nettype none
package sdh_pkg;
    localparam int MAX_LENGTH = 4096;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int RES_W      = 30;
    localparam int CNT_W      = $clog2(RES_W);

    typedef logic [RES_W-1:0] res_t;

    localparam res_t PRIME_A     = 30'd1000000007;
    localparam res_t PRIME_B     = 30'd1000000009;
    localparam res_t RADIX_A     = 30'd31;
    localparam res_t RADIX_B     = 30'd37;
    localparam res_t RADIX_A_INV = 30'd129032259;
    localparam res_t RADIX_B_INV = 30'd297297300;
    localparam logic [7:0] CHAR_OFFSET = 8'd96;

    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic start;
        logic sel_b;
        res_t a;
        res_t b;
    } mul_req_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [2*RES_W-1:0] pre;
        logic [2*RES_W-1:0] inv;
    } store_wr_t;

    // x + y mod p for x, y below p
    function automatic res_t add_mod(input res_t x, input res_t y, input res_t p);
        logic [RES_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[RES_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/sdh_modmul.sv =====
// Shared bit-serial modular multiplier, one multiplier bit per cycle.
// Depends on sdh_pkg.
`default_nettype none
module sdh_modmul import sdh_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output logic          done,
    output res_t          result
);
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic             sel_reg;
    res_t             a_reg, b_reg, acc_reg;
    res_t             p;
    logic [31:0]      dbl, p_w, red;

    always_comb
    begin
        p   = sel_reg ? PRIME_B : PRIME_A;
        p_w = {2'b00, p};
        dbl = {1'b0, acc_reg, 1'b0} + (b_reg[RES_W-1] ? {2'b00, a_reg} : 32'd0);
        if (dbl >= (p_w << 1))
            red = dbl - (p_w << 1);
        else if (dbl >= p_w)
            red = dbl - p_w;
        else
            red = dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RES_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            sel_reg <= req.sel_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= red[RES_W-1:0];
            b_reg   <= b_reg << 1;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule
`default_nettype wire

// ===== sv/sdh_store.sv =====
// Prefix and inverse power tables, both primes packed side by side.
// Depends on sdh_pkg.
`default_nettype none
module sdh_store import sdh_pkg::*; (
    input  wire logic              clk,
    input  wire store_wr_t         wr,
    input  wire logic [ADDR_W-1:0] pre_raddr,
    input  wire logic [ADDR_W-1:0] inv_raddr,
    output logic [2*RES_W-1:0]     pre_rdata,
    output logic [2*RES_W-1:0]     inv_rdata
);
    logic [2*RES_W-1:0] pre_mem [MAX_LENGTH];
    logic [2*RES_W-1:0] inv_mem [MAX_LENGTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            pre_mem[wr.addr] <= wr.pre;
            inv_mem[wr.addr] <= wr.inv;
        end
        pre_rdata <= pre_mem[pre_raddr];
        inv_rdata <= inv_mem[inv_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/substring_double_hash.sv =====
// Substring double hash: appends, in-range queries, restarts and rejected words;
// one word in at a time. Restart, rejected append or rejected query answers on done
// in the cycle after it is accepted. Each modular product runs on the single shared
// bit-serial multiplier (issue, 30 bit steps, done): six products per append, two per
// query, plus the table read states RD0, RD1 and RD2 per query. The result shows on
// done for one cycle; the receiver cannot stall it.
// Reset clears length, powers and control; table contents stay undefined.
`default_nettype none
module substring_double_hash import sdh_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  char_code,
    input  wire logic [11:0] left_index,
    input  wire logic [11:0] right_index,
    output logic             done,
    output logic [1:0]       status,
    output logic [29:0]      hash_first,
    output logic [29:0]      hash_second
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD0   = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    localparam logic [2:0] STEP_LAST_APPEND = 3'd5;
    localparam logic [2:0] STEP_LAST_QUERY  = 3'd1;
    localparam logic [2:0] STEP_PREFIX_B    = 3'd1;

    logic [2:0]       state_reg;
    logic [2:0]       step_reg;
    logic             query_reg;
    logic [LEN_W-1:0] len_reg;
    res_t bp_a_reg, bp_b_reg, ri_a_reg, ri_b_reg, last_a_reg, last_b_reg;
    res_t term_a_reg, term_b_reg, va_reg;
    res_t prehi_a_reg, prehi_b_reg, diff_a_reg, diff_b_reg, inv_a_reg, inv_b_reg;
    logic [ADDR_W-1:0] lo_reg, hi_reg;
    logic             done_reg;
    logic [1:0]       status_reg;
    res_t             hash_a_reg, hash_b_reg;

    mul_req_t  mul_req;
    logic      mul_done;
    res_t      mul_res;
    store_wr_t wr;
    logic [ADDR_W-1:0]  pre_raddr;
    logic [2*RES_W-1:0] pre_rdata, inv_rdata;

    logic accept, last_step, full, out_of_range;
    res_t term_a, term_b, below_a, below_b;

    sdh_modmul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_res)
    );

    sdh_store u_store (
        .clk       (clk),
        .wr        (wr),
        .pre_raddr (pre_raddr),
        .inv_raddr (lo_reg),
        .pre_rdata (pre_rdata),
        .inv_rdata (inv_rdata)
    );

    // Difference of prefixes mod p; the caller passes zero for the prefix below position zero.
    function automatic res_t sub_mod(input res_t x, input res_t y, input res_t p);
        logic [RES_W:0] s;
        s = {1'b0, x} + {1'b0, p} - {1'b0, y};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[RES_W-1:0];
    endfunction

    always_comb
    begin
        accept       = start && (state_reg == S_IDLE);
        full         = (len_reg == LEN_W'(MAX_LENGTH));
        out_of_range = ({1'b0, right_index} >= len_reg) || (left_index > right_index);
        last_step    = query_reg ? (step_reg == STEP_LAST_QUERY)
                                 : (step_reg == STEP_LAST_APPEND);

        // Character term, non-negative modulo each prime.
        if (char_code >= CHAR_OFFSET)
        begin
            term_a = RES_W'(char_code - CHAR_OFFSET);
            term_b = RES_W'(char_code - CHAR_OFFSET);
        end
        else
        begin
            term_a = PRIME_A - RES_W'(CHAR_OFFSET - char_code);
            term_b = PRIME_B - RES_W'(CHAR_OFFSET - char_code);
        end

        below_a = (lo_reg == '0) ? '0 : pre_rdata[2*RES_W-1:RES_W];
        below_b = (lo_reg == '0) ? '0 : pre_rdata[RES_W-1:0];

        // Hold the read address on the last position, then step to the one before left.
        pre_raddr = (state_reg == S_RD1) ? lo_reg - 1'b1 : hi_reg;

        mul_req.start = (state_reg == S_ISSUE);
        mul_req.sel_b = step_reg[0];
        case ({query_reg, step_reg})
            4'b0_000: begin mul_req.a = term_a_reg; mul_req.b = bp_a_reg;    end
            4'b0_001: begin mul_req.a = term_b_reg; mul_req.b = bp_b_reg;    end
            4'b0_010: begin mul_req.a = bp_a_reg;   mul_req.b = RADIX_A;     end
            4'b0_011: begin mul_req.a = bp_b_reg;   mul_req.b = RADIX_B;     end
            4'b0_100: begin mul_req.a = ri_a_reg;   mul_req.b = RADIX_A_INV; end
            4'b0_101: begin mul_req.a = ri_b_reg;   mul_req.b = RADIX_B_INV; end
            4'b1_000: begin mul_req.a = diff_a_reg; mul_req.b = inv_a_reg;   end
            4'b1_001: begin mul_req.a = diff_b_reg; mul_req.b = inv_b_reg;   end
            default:  begin mul_req.a = '0;         mul_req.b = '0;          end
        endcase

        // Write the new prefix pair once the second term product lands.
        wr.we   = (state_reg == S_WAIT) && mul_done && !query_reg
                  && (step_reg == STEP_PREFIX_B);
        wr.addr = len_reg[ADDR_W-1:0];
        wr.pre  = {add_mod(va_reg, last_a_reg, PRIME_A),
                   add_mod(mul_res, last_b_reg, PRIME_B)};
        wr.inv  = {ri_a_reg, ri_b_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            query_reg  <= 1'b0;
            len_reg    <= '0;
            bp_a_reg   <= 30'd1;
            bp_b_reg   <= 30'd1;
            ri_a_reg   <= 30'd1;
            ri_b_reg   <= 30'd1;
            last_a_reg <= '0;
            last_b_reg <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            hash_a_reg <= '0;
            hash_b_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg   <= '0;
                        status_reg <= STATUS_OK;
                        hash_a_reg <= '0;
                        hash_b_reg <= '0;
                        case (action)
                            ACT_APPEND:
                            begin
                                if (full)
                                begin
                                    status_reg <= STATUS_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    query_reg <= 1'b0;
                                    state_reg <= S_ISSUE;
                                end
                            end
                            ACT_QUERY:
                            begin
                                if (out_of_range)
                                begin
                                    status_reg <= STATUS_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    query_reg <= 1'b1;
                                    state_reg <= S_RD0;
                                end
                            end
                            ACT_RESTART:
                            begin
                                len_reg    <= '0;
                                bp_a_reg   <= 30'd1;
                                bp_b_reg   <= 30'd1;
                                ri_a_reg   <= 30'd1;
                                ri_b_reg   <= 30'd1;
                                last_a_reg <= '0;
                                last_b_reg <= '0;
                                done_reg   <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD0:   state_reg <= S_RD1;
                S_RD1:   state_reg <= S_RD2;
                S_RD2:   state_reg <= S_ISSUE;
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (query_reg)
                        begin
                            if (step_reg == '0)
                                hash_a_reg <= mul_res;
                            else
                                hash_b_reg <= mul_res;
                        end
                        else
                        begin
                            case (step_reg)
                                3'd1:
                                begin
                                    last_a_reg <= wr.pre[2*RES_W-1:RES_W];
                                    last_b_reg <= wr.pre[RES_W-1:0];
                                end
                                3'd2: bp_a_reg <= mul_res;
                                3'd3: bp_b_reg <= mul_res;
                                3'd4: ri_a_reg <= mul_res;
                                3'd5:
                                begin
                                    ri_b_reg <= mul_res;
                                    len_reg  <= len_reg + 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        if (last_step)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            term_a_reg <= term_a;
            term_b_reg <= term_b;
            lo_reg     <= left_index;
            hi_reg     <= right_index;
        end
        if (state_reg == S_WAIT && mul_done && !query_reg && step_reg == '0)
            va_reg <= mul_res;
        if (state_reg == S_RD1)
        begin
            prehi_a_reg <= pre_rdata[2*RES_W-1:RES_W];
            prehi_b_reg <= pre_rdata[RES_W-1:0];
        end
        if (state_reg == S_RD2)
        begin
            diff_a_reg <= sub_mod(prehi_a_reg, below_a, PRIME_A);
            diff_b_reg <= sub_mod(prehi_b_reg, below_b, PRIME_B);
            inv_a_reg  <= inv_rdata[2*RES_W-1:RES_W];
            inv_b_reg  <= inv_rdata[RES_W-1:0];
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign hash_first  = hash_a_reg;
    assign hash_second = hash_b_reg;
endmodule
`default_nettype wire

// ===== sv/sdh_checker.sv =====
// Port-level checker of the substring double hash block, bound to the top level.
// Depends on sdh_pkg and substring_double_hash_defines.svh.
`default_nettype none
`include "substring_double_hash_defines.svh"
module sdh_checker import sdh_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  action,
    input wire logic [7:0]  char_code,
    input wire logic [11:0] left_index,
    input wire logic [11:0] right_index,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [29:0] hash_first,
    input wire logic [29:0] hash_second
);
    `SDH_ASSERT_SAME(a_done_idle, done, !busy)
    `SDH_ASSERT_SAME(a_err_zero, done && status != STATUS_OK, hash_first == '0 && hash_second == '0)
    `SDH_ASSERT_NEXT(a_restart_fast, start && !busy && action == ACT_RESTART, done && status == STATUS_OK)
    `SDH_ASSERT_NEXT(a_busy_no_done, busy && !done, !done || !busy)
endmodule

bind substring_double_hash sdh_checker u_sdh_checker (.*);
`default_nettype wire

// ===== tb/substring_double_hash_checker.sv =====
// Checker for the substring double hash block: predicts each result word from
// accepted commands and compares it with the done strobe. Depends on sdh_pkg.
module substring_double_hash_checker import sdh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [11:0] left_index,
    input  logic [11:0] right_index,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [29:0] hash_first,
    input  logic [29:0] hash_second,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  st;
        logic [29:0] h1;
        logic [29:0] h2;
    } hash_word_t;

    hash_word_t expected_words[$];
    logic [29:0] pre_a[MAX_LENGTH];
    logic [29:0] pre_b[MAX_LENGTH];
    logic [29:0] inv_a[MAX_LENGTH];
    logic [29:0] inv_b[MAX_LENGTH];
    int unsigned str_len;
    logic [29:0] pow_a, pow_b, rinv_a, rinv_b;

    function automatic logic [29:0] mulm(logic [29:0] x, logic [29:0] y, logic [29:0] p);
        logic [63:0] prod;
        prod = 64'(x) * 64'(y);
        return 30'(prod % 64'(p));
    endfunction

    function automatic logic [29:0] span_hash(logic [29:0] hi_pre, logic [29:0] lo_pre,
                                              logic [29:0] inv, logic [29:0] p);
        logic [63:0] d;
        d = (64'(hi_pre) + 64'(p) - 64'(lo_pre)) % 64'(p);
        return mulm(30'(d), inv, p);
    endfunction

    // Advance the string model by one command word and return the expected word.
    function automatic hash_word_t predict_hash_word(logic [1:0] act, logic [7:0] code,
                                                     logic [11:0] lo, logic [11:0] hi);
        hash_word_t w;
        logic [63:0] ta, tb, va, vb;
        w = '0;
        if (act == ACT_APPEND) begin
            if (str_len >= MAX_LENGTH)
                w.st = STATUS_FULL;
            else
            begin
                ta = (64'(code) + 64'(PRIME_A) - 64'(CHAR_OFFSET)) % 64'(PRIME_A);
                tb = (64'(code) + 64'(PRIME_B) - 64'(CHAR_OFFSET)) % 64'(PRIME_B);
                va = 64'(mulm(30'(ta), pow_a, PRIME_A));
                vb = 64'(mulm(30'(tb), pow_b, PRIME_B));
                if (str_len > 0)
                begin
                    va = (va + 64'(pre_a[str_len-1])) % 64'(PRIME_A);
                    vb = (vb + 64'(pre_b[str_len-1])) % 64'(PRIME_B);
                end
                pre_a[str_len] = 30'(va);
                pre_b[str_len] = 30'(vb);
                inv_a[str_len] = rinv_a;
                inv_b[str_len] = rinv_b;
                pow_a  = mulm(pow_a, RADIX_A, PRIME_A);
                pow_b  = mulm(pow_b, RADIX_B, PRIME_B);
                rinv_a = mulm(rinv_a, RADIX_A_INV, PRIME_A);
                rinv_b = mulm(rinv_b, RADIX_B_INV, PRIME_B);
                str_len++;
            end
        end
        else if (act == ACT_QUERY) begin
            if (hi >= str_len || lo > hi)
                w.st = STATUS_RANGE;
            else
            begin
                w.h1 = span_hash(pre_a[hi], lo ? pre_a[lo-1] : 30'd0, inv_a[lo], PRIME_A);
                w.h2 = span_hash(pre_b[hi], lo ? pre_b[lo-1] : 30'd0, inv_b[lo], PRIME_B);
            end
        end
        else if (act == ACT_RESTART) begin
            str_len = 0;
            pow_a = 1; pow_b = 1; rinv_a = 1; rinv_b = 1;
        end
        return w;
    endfunction

    assign pending = expected_words.size();

    initial begin
        fail_count = 0;
        str_len = 0;
        pow_a = 1; pow_b = 1; rinv_a = 1; rinv_b = 1;
    end

    // Sample both channels at the edge; a result comes back in the cycle after its command at the earliest.
    always @(posedge clk)
    begin
        hash_word_t got, want;
        if (rst_n) begin
            if (done) begin
                got = '{status, hash_first, hash_second};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word status=%0d h1=%0d h2=%0d",
                             $time, status, hash_first, hash_second);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                        fail_count++;
                    end
                    if (got.h1 !== want.h1) begin
                        $display("%0t: hash_first expected %0d actual %0d",
                                 $time, want.h1, got.h1);
                        fail_count++;
                    end
                    if (got.h2 !== want.h2) begin
                        $display("%0t: hash_second expected %0d actual %0d",
                                 $time, want.h2, got.h2);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_hash_word(action, char_code,
                                                           left_index, right_index));
        end
    end
endmodule

// ===== tb/substring_double_hash_tb.sv =====
// Testbench top for the substring double hash block: drives command words and
// gives the verdict. Depends on sdh_pkg, substring_double_hash and its checker.
module substring_double_hash_tb;
    import sdh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [11:0] left_index;
    logic [11:0] right_index;
    logic        done;
    logic [1:0]  status;
    logic [29:0] hash_first;
    logic [29:0] hash_second;
    int          fail_count;
    int          pending;
    int          idle_pct;   // sender idle chance in percent
    int unsigned model_len;  // string length as the stimulus tracks it

    substring_double_hash DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .char_code(char_code),
        .left_index(left_index), .right_index(right_index),
        .done(done), .status(status),
        .hash_first(hash_first), .hash_second(hash_second)
    );

    substring_double_hash_checker hash_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .char_code(char_code),
        .left_index(left_index), .right_index(right_index),
        .done(done), .status(status),
        .hash_first(hash_first), .hash_second(hash_second),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard stop: several times the run time of about 5700 words plus gaps.
    initial begin
        #40ms;
        $display("substring_double_hash_tb: errors");
        $finish;
    end

    // Drop start while the idle draw says to wait, then present one command
    // word and hold it while busy is high; start stays high for back to back words.
    task automatic send_word(logic [1:0] act, logic [7:0] code,
                             logic [11:0] lo, logic [11:0] hi);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        char_code   <= code;
        left_index  <= lo;
        right_index <= hi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Track the length so queries can be aimed inside the string.
        if (act == ACT_APPEND && model_len < MAX_LENGTH)
            model_len++;
        else if (act == ACT_RESTART)
            model_len = 0;
    endtask

    task automatic send_append(logic [7:0] code);
        send_word(ACT_APPEND, code, 12'($urandom), 12'($urandom));
    endtask

    task automatic send_query(logic [11:0] lo, logic [11:0] hi);
        send_word(ACT_QUERY, 8'($urandom), lo, hi);
    endtask

    // Mostly in-range queries over the current string, some out of range.
    task automatic random_query();
        logic [11:0] lo, hi;
        if (model_len > 0 && $urandom_range(9) < 8) begin
            hi = 12'($urandom_range(model_len - 1));
            lo = 12'($urandom_range(hi));
        end
        else
        begin
            lo = 12'($urandom);
            hi = 12'($urandom);
        end
        send_query(lo, hi);
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_append(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122)));
        else if (pick < 92)
            random_query();
        else if (pick < 96)
            send_word(ACT_RESTART, 8'($urandom), 12'($urandom), 12'($urandom));
        else
            send_word(2'd3, 8'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int k;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_APPEND;
        char_code   = '0;
        left_index  = '0;
        right_index = '0;
        idle_pct    = 0;
        model_len   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: queries on an empty string, code extremes, range edges.
        send_query(12'd0, 12'd0);
        send_append(8'd0);
        send_append(8'd255);
        send_append(8'd96);
        send_append(8'd97);
        send_append(8'd122);
        send_query(12'd0, 12'd4);
        send_query(12'd0, 12'd0);
        send_query(12'd4, 12'd4);
        send_query(12'd2, 12'd3);
        send_query(12'd3, 12'd2);
        send_query(12'd0, 12'd5);
        send_query(12'd4095, 12'd4095);
        send_query(12'd4095, 12'd0);
        send_word(2'd3, 8'hff, 12'hfff, 12'hfff);
        send_word(ACT_RESTART, 8'h00, 12'h000, 12'h000);
        send_query(12'd0, 12'd0);
        send_append(8'd98);
        send_query(12'd0, 12'd0);

        // Hold off until every result has come back.
        drain();

        // Fill the store to its limit with no idling, then hit full.
        send_word(ACT_RESTART, 8'd0, 12'd0, 12'd0);
        while (model_len < MAX_LENGTH)
            send_append(8'($urandom));
        send_append(8'h55);
        send_query(12'd0, 12'd4095);
        send_query(12'd4095, 12'd4095);
        send_query(12'd1234, 12'd4000);
        send_word(ACT_RESTART, 8'd0, 12'd0, 12'd0);

        // Random phases: sender idles 14%, then 76%, then never.
        for (k = 0; k < 1550; k++) begin
            idle_pct = (k < 520) ? 14 : (k < 1040) ? 76 : 0;
            random_word();
        end

        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("substring_double_hash_tb: clean");
        else
            $display("substring_double_hash_tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sdh_pkg.sv
sv/sdh_modmul.sv
sv/sdh_store.sv
sv/substring_double_hash.sv
sv/sdh_checker.sv
tb/substring_double_hash_checker.sv
tb/substring_double_hash_tb.sv
